/* src/tlbs_pkg.sv */
// Shared types and codes for the table search block.
// No dependencies; top, search and testbench import it.
package tlbs_pkg;

	typedef logic [1:0] req_code_t;
	typedef logic [2:0] status_t;

	localparam req_code_t REQ_APPEND = 2'd0;
	localparam req_code_t REQ_SEARCH = 2'd1;
	localparam req_code_t REQ_CLEAR  = 2'd2;

	localparam status_t ST_FOUND      = 3'd0;
	localparam status_t ST_NOT_FOUND  = 3'd1;
	localparam status_t ST_NOT_SORTED = 3'd2;
	localparam status_t ST_DONE       = 3'd3;
	localparam status_t ST_FULL       = 3'd4;

	typedef struct packed {
		logic               start;
		logic               binary;
		logic signed [31:0] key;
	} search_cmd_t;

	typedef struct packed {
		logic       done;
		status_t    status;
		logic [7:0] index;
	} search_res_t;

endpackage

/* src/tlbs_if.sv */
// Valid/ready channel interfaces for request and response items.
// Payload widths are fixed by the item formats; no package needed.
interface tlbs_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] item_value;

	modport source(output valid, output req_type, output item_value, input ready);
	modport sink(input valid, input req_type, input item_value, output ready);
endinterface

interface tlbs_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] found_index;

	modport source(output valid, output status, output found_index, input ready);
	modport sink(input valid, input status, input found_index, output ready);
endinterface

/* src/table_linear_binary_search.sv */
// Top level of the table search block: table bookkeeping, response register,
// table RAM and search sequencer. Depends on tlbs_pkg, tlbs_if, tlbs_ram, tlbs_search.
//
//   channel  | role   | payload                  | handshake
//   req      | sink   | req_type, item_value     | valid/ready
//   rsp      | source | status, found_index      | valid/ready
//   cfg      | write  | cfg_wdata (search_mode)  | cfg_we, no wait
//
// Append, clear and unused codes: result registered in the cycle after acceptance.
// Linear search: one RAM read per cycle.
// Binary search: each probe reads the RAM in S_BRD and compares in S_BCMP.
// Not sorted and empty table answer at once.
// Reset clears count, order flag, mode and valid flags; table RAM is not cleared.
// req.ready is low during a search and while an unread response is held.
module table_linear_binary_search #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	tlbs_req_if.sink   req,
	tlbs_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic cfg_wdata
);
	import tlbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic               mode_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] last_q;
	logic               sorted_q;
	logic               rsp_valid_q;
	status_t            status_q;
	logic [7:0]         index_q;

	logic        accept;
	logic        full;
	logic        core_idle;
	logic        rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0] rd_data;
	logic        wr_en;
	search_cmd_t cmd;
	search_res_t res;
	logic        load;
	status_t     load_status;

	assign req.ready = core_idle && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign full      = count_q == DEPTH_C;
	assign wr_en     = accept && req.req_type == REQ_APPEND && !full;

	assign cmd.start  = accept && req.req_type == REQ_SEARCH && count_q != '0
		&& !(mode_q && !sorted_q);
	assign cmd.binary = mode_q;
	assign cmd.key    = req.item_value;

	always_comb begin
		load        = accept && !cmd.start;
		load_status = ST_NOT_FOUND;
		case (req.req_type)
			REQ_APPEND: load_status = full ? ST_FULL : ST_DONE;
			REQ_CLEAR:  load_status = ST_DONE;
			REQ_SEARCH: load_status = (mode_q && !sorted_q) ? ST_NOT_SORTED : ST_NOT_FOUND;
			default:    load_status = ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			count_q     <= '0;
			last_q      <= '0;
			sorted_q    <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (wr_en) begin
				if (count_q != '0 && last_q > req.item_value) begin
					sorted_q <= 1'b0;
				end
				count_q <= count_q + CW'(1);
				last_q  <= req.item_value;
			end
			if (accept && req.req_type == REQ_CLEAR) begin
				count_q  <= '0;
				last_q   <= '0;
				sorted_q <= 1'b1;
			end
			if (load || res.done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= load_status;
			index_q  <= '0;
		end else if (res.done) begin
			status_q <= res.status;
			index_q  <= res.index;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_index = index_q;

	tlbs_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata(req.item_value),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	tlbs_search #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.count  (count_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.idle   (core_idle),
		.res    (res)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond table depth");

	a_item_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q || !core_idle)
		else $error("accepted item left no result and no search");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !rsp_valid_q)
		else $error("search result would overwrite held response");

endmodule

/* src/tlbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/tlbs_search.sv */
// Search sequencer: linear scan or bisection over the table RAM read port,
// one 32-bit equality compare for both modes and a greater-than compare for bisection. Depends on tlbs_pkg.
module tlbs_search #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tlbs_pkg::search_cmd_t            cmd,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
	output logic                             rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
	input  logic [31:0]                      rd_data,
	output logic                             idle,
	output tlbs_pkg::search_res_t            res
);
	import tlbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic signed [CW:0] ONE = (CW+1)'(1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LIN  = 4'b0010,
		S_BRD  = 4'b0100,
		S_BCMP = 4'b1000
	} state_t;

	state_t             state_q;
	logic signed [31:0] key_q;
	logic [CW-1:0]      next_q;
	logic               pend_q;
	logic [AW-1:0]      pend_addr_q;
	logic signed [CW:0] lo_q;
	logic signed [CW:0] hi_q;
	logic [AW-1:0]      mid_q;

	logic signed [CW+1:0] sum;
	logic [AW-1:0]        mid;
	logic                 more;
	logic                 hit;
	logic                 lo_gt_hi;
	logic signed [CW:0]   mid_ext;

	assign sum      = {lo_q[CW], lo_q} + {hi_q[CW], hi_q};
	assign mid      = sum[AW:1];
	assign more     = next_q < count;
	assign hit      = $signed(rd_data) == key_q;
	assign lo_gt_hi = lo_q > hi_q;
	assign mid_ext  = $signed({{(CW+1-AW){1'b0}}, mid_q});
	assign idle     = state_q == S_IDLE;

	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = '0;
		res.done   = 1'b0;
		res.status = ST_NOT_FOUND;
		res.index  = '0;
		case (state_q)
			S_LIN: begin
				if (pend_q && hit) begin
					res.done   = 1'b1;
					res.status = ST_FOUND;
					res.index  = 8'(pend_addr_q);
				end else if (more) begin
					rd_en   = 1'b1;
					rd_addr = next_q[AW-1:0];
				end else begin
					res.done = 1'b1;
				end
			end
			S_BRD: begin
				if (lo_gt_hi) begin
					res.done = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = mid;
				end
			end
			S_BCMP: begin
				if (hit) begin
					res.done   = 1'b1;
					res.status = ST_FOUND;
					res.index  = 8'(mid_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					pend_q <= 1'b0;
					if (cmd.start) begin
						state_q <= cmd.binary ? S_BRD : S_LIN;
					end
				end
				S_LIN: begin
					if ((pend_q && hit) || !more) begin
						state_q <= S_IDLE;
						pend_q  <= 1'b0;
					end else begin
						pend_q <= 1'b1;
					end
				end
				S_BRD: begin
					state_q <= lo_gt_hi ? S_IDLE : S_BCMP;
				end
				S_BCMP: begin
					state_q <= hit ? S_IDLE : S_BRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q  <= cmd.key;
				next_q <= '0;
				lo_q   <= '0;
				hi_q   <= $signed({1'b0, count}) - ONE;
			end
			S_LIN: begin
				next_q      <= next_q + CW'(1);
				pend_addr_q <= next_q[AW-1:0];
			end
			S_BRD: begin
				mid_q <= mid;
			end
			S_BCMP: begin
				if ($signed(rd_data) > key_q) begin
					hi_q <= mid_ext - ONE;
				end else begin
					lo_q <= mid_ext + ONE;
				end
			end
			default: begin
			end
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == S_IDLE)
		else $error("search started while busy");

	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BCMP |-> $past(state_q) == S_BRD)
		else $error("compare without a preceding probe");

	a_addr_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> CW'(rd_addr) < count)
		else $error("read beyond filled entries");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> state_q == S_IDLE)
		else $error("sequencer not idle after result");

endmodule

/* tb/tb.sv */
// Self-checking testbench for table_linear_binary_search: appends, clears,
// unused codes, linear or binary searches, checked item by item against
// an in-bench table model or a directed row's fixed result. Depends on tlbs_pkg, tlbs_if and the block's RTL.
module tb;
	import tlbs_pkg::*;

	localparam req_code_t REQ_UNUSED = 2'd3;
	localparam int DEPTH = 256;
	localparam int QUIET_LIMIT = 4000;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		bit                 cfg;
		req_code_t          rq;
		logic signed [31:0] v;
		bit                 typed;
		status_t            st;
		logic [7:0]         ix;
	} plan_row_t;

	typedef struct packed {
		status_t    st;
		logic [7:0] ix;
	} lookup_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	tlbs_req_if req_ch();
	tlbs_rsp_if rsp_ch();

	table_linear_binary_search u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// table model
	logic signed [31:0] table_copy [DEPTH];
	int                 table_len = 0;
	logic signed [31:0] tail_value = '0;
	bit                 table_ordered = 1'b1;
	bit                 binary_mode = 1'b0;

	lookup_result_t pending_results [$];
	bit   steady_flow = 1'b0;
	int   n_items = 0;
	int   n_results = 0;
	int   n_found = 0;
	int   n_unsorted = 0;
	int   n_full = 0;
	int   n_mode_writes = 0;
	int   n_errors = 0;
	int   quiet_cycles = 0;

	plan_row_t directed_plan [0:24] = '{
		'{1'b0, REQ_SEARCH, 32'sd0,  1'b1, ST_NOT_FOUND, 8'd0},
		'{1'b0, REQ_UNUSED, 32'sd0,  1'b1, ST_NOT_FOUND, 8'd0},
		'{1'b0, REQ_APPEND, VAL_MIN, 1'b1, ST_DONE,      8'd0},
		'{1'b0, REQ_APPEND, -32'sd1, 1'b1, ST_DONE,      8'd0},
		'{1'b0, REQ_APPEND, 32'sd0,  1'b1, ST_DONE,      8'd0},
		'{1'b0, REQ_APPEND, VAL_MAX, 1'b1, ST_DONE,      8'd0},
		'{1'b0, REQ_SEARCH, VAL_MIN, 1'b1, ST_FOUND,     8'd0},
		'{1'b0, REQ_SEARCH, VAL_MAX, 1'b0, ST_FOUND,     8'd0},
		'{1'b0, REQ_APPEND, 32'sd5,  1'b1, ST_DONE,      8'd0},
		'{1'b0, REQ_SEARCH, 32'sd5,  1'b0, ST_FOUND,     8'd0},
		'{1'b1, REQ_APPEND, 32'sd1,  1'b0, ST_DONE,      8'd0},
		'{1'b0, REQ_SEARCH, 32'sd0,  1'b1, ST_NOT_SORTED, 8'd0},
		'{1'b0, REQ_CLEAR,  32'sd0,  1'b1, ST_DONE,      8'd0},
		'{1'b0, REQ_SEARCH, 32'sd7,  1'b1, ST_NOT_FOUND, 8'd0},
		'{1'b0, REQ_APPEND, -32'sd5, 1'b0, ST_DONE,      8'd0},
		'{1'b0, REQ_APPEND, -32'sd5, 1'b0, ST_DONE,      8'd0},
		'{1'b0, REQ_APPEND, 32'sd3,  1'b0, ST_DONE,      8'd0},
		'{1'b0, REQ_APPEND, 32'sd3,  1'b0, ST_DONE,      8'd0},
		'{1'b0, REQ_APPEND, 32'sd9,  1'b0, ST_DONE,      8'd0},
		'{1'b0, REQ_SEARCH, 32'sd3,  1'b0, ST_FOUND,     8'd0},
		'{1'b0, REQ_SEARCH, -32'sd5, 1'b0, ST_FOUND,     8'd0},
		'{1'b0, REQ_SEARCH, 32'sd4,  1'b0, ST_FOUND,     8'd0},
		'{1'b0, REQ_SEARCH, 32'sd9,  1'b0, ST_FOUND,     8'd0},
		'{1'b0, REQ_UNUSED, 32'sd0,  1'b1, ST_NOT_FOUND, 8'd0},
		'{1'b1, REQ_APPEND, 32'sd0,  1'b0, ST_DONE,      8'd0}
	};

	function automatic lookup_result_t predict_lookup(input req_code_t rq,
			input logic signed [31:0] v);
		lookup_result_t r;
		int lo;
		int hi;
		int mid;
		r.st = ST_NOT_FOUND;
		r.ix = '0;
		case (rq)
			REQ_APPEND: begin
				if (table_len >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					if (table_len > 0 && tail_value > v)
						table_ordered = 1'b0;
					table_copy[table_len] = v;
					table_len++;
					tail_value = v;
					r.st = ST_DONE;
				end
			end
			REQ_SEARCH: begin
				if (!binary_mode) begin
					for (int i = 0; i < table_len; i++) begin
						if (table_copy[i] == v) begin
							r.st = ST_FOUND;
							r.ix = i[7:0];
							break;
						end
					end
				end else if (!table_ordered) begin
					r.st = ST_NOT_SORTED;
				end else begin
					lo = 0;
					hi = table_len - 1;
					while (lo <= hi) begin
						mid = (lo + hi) / 2;
						if (table_copy[mid] == v) begin
							r.st = ST_FOUND;
							r.ix = mid[7:0];
							break;
						end
						if (table_copy[mid] > v)
							hi = mid - 1;
						else
							lo = mid + 1;
					end
				end
			end
			REQ_CLEAR: begin
				table_len = 0;
				tail_value = '0;
				table_ordered = 1'b1;
				r.st = ST_DONE;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(input req_code_t rq, input logic signed [31:0] v,
			input bit typed = 1'b0, input status_t tst = ST_DONE,
			input logic [7:0] tix = 8'd0);
		int gap;
		lookup_result_t r;
		gap = steady_flow ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rq;
		req_ch.item_value <= v;
		do @(posedge clk); while (!req_ch.ready);
		r = predict_lookup(rq, v);
		if (typed) begin
			r.st = tst;
			r.ix = tix;
		end
		pending_results.push_back(r);
		n_items++;
		@(negedge clk);
	endtask

	// hold off until every result is back and the block is idle
	task automatic drain;
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mode(input bit m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		binary_mode = m;
		n_mode_writes++;
	endtask

	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (table_len > 0 && r < 6)
			return table_copy[$urandom_range(0, table_len - 1)];
		if (table_len > 0 && r < 8)
			return table_copy[$urandom_range(0, table_len - 1)]
				+ ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
		if (r == 8)
			return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
		return $urandom;
	endfunction

	task automatic run_phase(input bit fill_up);
		int n;
		int m;
		bit wide;
		longint cur;
		longint lowered;
		drain();
		write_mode($urandom_range(0, 1));
		steady_flow = ($urandom_range(0, 3) == 0);
		send_item(REQ_CLEAR, $urandom);
		wide = $urandom_range(0, 1);
		if (fill_up)
			n = DEPTH + $urandom_range(2, 4);
		else if ($urandom_range(0, 3) == 0)
			n = $urandom_range(0, 4);
		else
			n = $urandom_range(5, 40);
		cur = wide ? longint'(signed'(VAL_MIN)) + $urandom_range(0, 1 << 20)
			: longint'($urandom_range(0, 20)) - 10;
		for (int i = 0; i < n; i++) begin
			cur += wide ? $urandom_range(0, 1 << 24) : $urandom_range(0, 2);
			if (cur > longint'(VAL_MAX))
				cur = VAL_MAX;
			send_item(REQ_APPEND, cur[31:0]);
		end
		// now and then break the ordering
		if (!fill_up && $urandom_range(0, 3) == 0) begin
			lowered = cur - 1 - $urandom_range(0, 5);
			if (lowered < longint'(signed'(VAL_MIN)))
				lowered = VAL_MIN;
			send_item(REQ_APPEND, lowered[31:0]);
		end
		m = fill_up ? 6 : $urandom_range(5, 20);
		for (int i = 0; i < m; i++) begin
			case ($urandom_range(0, 19))
				0: send_item(REQ_UNUSED, $urandom);
				1: send_item(REQ_APPEND, pick_key());
				default: send_item(REQ_SEARCH, pick_key());
			endcase
		end
		if (fill_up && table_len > 0)
			send_item(REQ_SEARCH, table_copy[table_len - 1]);
	endtask

	// response side
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			case (rsp_ch.status)
				ST_FOUND: n_found++;
				ST_NOT_SORTED: n_unsorted++;
				ST_FULL: n_full++;
				default: ;
			endcase
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result: status %0d index %0d",
						rsp_ch.status, rsp_ch.found_index);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.st || rsp_ch.found_index !== want.ix) begin
					n_errors++;
					if (n_errors <= 10)
						$display("result %0d: expected status %0d index %0d, got status %0d index %0d",
							n_results, want.st, want.ix, rsp_ch.status,
							rsp_ch.found_index);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_APPEND;
		req_ch.item_value = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].cfg) begin
				drain();
				write_mode(directed_plan[i].v[0]);
			end else begin
				send_item(directed_plan[i].rq, directed_plan[i].v, directed_plan[i].typed,
					directed_plan[i].st, directed_plan[i].ix);
			end
		end

		phase = 0;
		while (n_items < 620) begin
			run_phase(phase == 2);
			phase++;
		end

		drain();
		repeat (300) @(negedge clk);
		$display("Ran %0d items in %0d phases with %0d mode writes; %0d results,",
			n_items, phase, n_mode_writes, n_results);
		$display("  %0d found, %0d not sorted, %0d table full", n_found, n_unsorted,
			n_full);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
